// ===== rtl/c2s_pkg.sv =====
`timescale 1ns / 1ps

package c2s_pkg;

    localparam int ROWS    = 64;
    localparam int COLUMNS = 512;

    localparam int ROW_W = 8;
    localparam int COL_W = 9;
    localparam int BND_W = 9;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(ROWS + 1);

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

    typedef struct packed {
        logic [BND_W-1:0] t1s;
        logic [BND_W-1:0] t1e;
        logic [BND_W-1:0] b1e;
        logic [BND_W-1:0] b1s;
        logic [BND_W-1:0] t2s;
        logic [BND_W-1:0] t2e;
        logic [BND_W-1:0] b2e;
        logic [BND_W-1:0] b2s;
    } t_bounds;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] start;
    } t_slot;

    typedef struct packed {
        logic             load_top;
        logic             load_bot;
        logic             shift;
        logic             shift_up;
        logic             open_wr;
        logic [COL_W-1:0] col;
    } t_cell_ctrl;

endpackage

// ===== rtl/c2s_cell.sv =====
`timescale 1ns / 1ps

module c2s_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [c2s_pkg::RW-1:0]  i_index,
    input  c2s_pkg::t_bounds        i_bnd,
    input  c2s_pkg::t_cell_ctrl     i_ctrl,
    input  c2s_pkg::t_slot          i_from_lo,
    input  c2s_pkg::t_slot          i_from_hi,
    output c2s_pkg::t_slot          o_slot
);

    logic [c2s_pkg::BND_W-1:0] idx;
    logic                      top_close;
    logic                      bot_close;
    logic                      opens;

    logic [c2s_pkg::COL_W-1:0] r_start;
    logic [c2s_pkg::COL_W-1:0] n_start;
    c2s_pkg::t_slot            r_slot;
    c2s_pkg::t_slot            n_slot;

    assign idx       = c2s_pkg::BND_W'(i_index);
    assign top_close = (idx >= i_bnd.t1s) && (idx < i_bnd.t1e);
    assign bot_close = (idx > i_bnd.b1e) && (idx <= i_bnd.b1s);
    assign opens     = ((idx >= i_bnd.t2s) && (idx < i_bnd.t2e)) ||
                       ((idx > i_bnd.b2e) && (idx <= i_bnd.b2s));

    always_comb begin
        n_start = r_start;
        if (i_ctrl.open_wr && opens) begin
            n_start = i_ctrl.col;
        end
    end

    always_comb begin
        n_slot = r_slot;
        if (i_ctrl.load_top) begin
            n_slot.valid = top_close;
            n_slot.start = r_start;
        end else if (i_ctrl.load_bot) begin
            n_slot.valid = bot_close;
            n_slot.start = r_start;
        end else if (i_ctrl.shift) begin
            n_slot = i_ctrl.shift_up ? i_from_lo : i_from_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start      <= '0;
            r_slot.valid <= 1'b0;
            r_slot.start <= '0;
        end else begin
            r_start <= n_start;
            r_slot  <= n_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

// ===== rtl/c2s_chain.sv =====
`timescale 1ns / 1ps

module c2s_chain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  c2s_pkg::t_bounds    i_bnd,
    input  c2s_pkg::t_cell_ctrl i_ctrl,
    output c2s_pkg::t_slot      o_head_lo,
    output c2s_pkg::t_slot      o_head_hi
);

    c2s_pkg::t_slot slot_q  [c2s_pkg::ROWS];
    c2s_pkg::t_slot from_lo [c2s_pkg::ROWS];
    c2s_pkg::t_slot from_hi [c2s_pkg::ROWS];

    for (genvar g = 0; g < c2s_pkg::ROWS; g++) begin : g_cell
        if (g == 0) begin : g_lo_end
            assign from_lo[g] = '0;
        end else begin : g_lo_link
            assign from_lo[g] = slot_q[g-1];
        end

        if (g == c2s_pkg::ROWS - 1) begin : g_hi_end
            assign from_hi[g] = '0;
        end else begin : g_hi_link
            assign from_hi[g] = slot_q[g+1];
        end

        c2s_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_index   (c2s_pkg::RW'(g)),
            .i_bnd     (i_bnd),
            .i_ctrl    (i_ctrl),
            .i_from_lo (from_lo[g]),
            .i_from_hi (from_hi[g]),
            .o_slot    (slot_q[g])
        );
    end

    assign o_head_lo = slot_q[0];
    assign o_head_hi = slot_q[c2s_pkg::ROWS-1];

endmodule

// ===== rtl/column_to_span_converter.sv =====
`timescale 1ns / 1ps

// channel  direction  handshake                  payload
// input    in         i_in_valid / o_in_stall    i_column, i_prev_top, i_prev_bottom,
//                                                i_cur_top, i_cur_bottom
// output   out        o_out_valid / i_out_stall  o_span_row, o_span_first, o_span_final,
//                                                o_last_span
//
// One transaction at a time: the idle state that takes it, then calc, two loads, two end
// checks and the start update, plus the shifts that bring the last top span to cell 0
// and the last bottom span to the last cell. The two shift runs together never pass ROWS.
// Reset clears every stored span start to zero at once; no clearing pass follows.
// A stall on the output holds the chain while a span waits at its end.

module column_to_span_converter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [c2s_pkg::COL_W-1:0]     i_column,
    input  logic [c2s_pkg::ROW_W-1:0]     i_prev_top,
    input  logic [c2s_pkg::ROW_W-1:0]     i_prev_bottom,
    input  logic [c2s_pkg::ROW_W-1:0]     i_cur_top,
    input  logic [c2s_pkg::ROW_W-1:0]     i_cur_bottom,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [c2s_pkg::ROW_W-1:0]     o_span_row,
    output logic [c2s_pkg::COL_W-1:0]     o_span_first,
    output logic [c2s_pkg::COL_W-1:0]     o_span_final,
    output logic                          o_last_span
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CALC   = 7'b0000010,
        S_TLOAD  = 7'b0000100,
        S_TSHIFT = 7'b0001000,
        S_BLOAD  = 7'b0010000,
        S_BSHIFT = 7'b0100000,
        S_OPEN   = 7'b1000000
    } t_state;

    t_state                       r_state;
    t_state                       n_state;

    logic [c2s_pkg::COL_W-1:0]    r_col;
    logic [c2s_pkg::ROW_W-1:0]    r_pt;
    logic [c2s_pkg::ROW_W-1:0]    r_pb;
    logic [c2s_pkg::ROW_W-1:0]    r_ct;
    logic [c2s_pkg::ROW_W-1:0]    r_cb;
    logic [c2s_pkg::COL_W-1:0]    r_final;
    c2s_pkg::t_bounds             r_bnd;
    c2s_pkg::t_bounds             n_bnd;
    logic [c2s_pkg::CW-1:0]       r_phase_left;
    logic [c2s_pkg::CW-1:0]       r_nbot;
    logic [c2s_pkg::CW-1:0]       r_left;
    logic [c2s_pkg::RW-1:0]       r_row;

    logic                         r_out_valid;
    logic [c2s_pkg::ROW_W-1:0]    r_span_row;
    logic [c2s_pkg::COL_W-1:0]    r_span_first;
    logic [c2s_pkg::COL_W-1:0]    r_span_final;
    logic                         r_last_span;

    logic [c2s_pkg::BND_W-1:0]    t1s;
    logic [c2s_pkg::BND_W-1:0]    b1s;
    logic [c2s_pkg::BND_W-1:0]    t2s;
    logic [c2s_pkg::BND_W-1:0]    b2s;
    logic [c2s_pkg::BND_W-1:0]    t1e;
    logic [c2s_pkg::BND_W-1:0]    b1e;
    logic [c2s_pkg::BND_W-1:0]    t2e;
    logic [c2s_pkg::BND_W-1:0]    b2e;
    logic [c2s_pkg::CW-1:0]       ntop;
    logic [c2s_pkg::CW-1:0]       nbot;

    logic                         in_accept;
    logic                         advance;
    logic                         in_shift;
    c2s_pkg::t_slot               head;
    c2s_pkg::t_slot               head_lo;
    c2s_pkg::t_slot               head_hi;
    logic                         emit;
    c2s_pkg::t_cell_ctrl          ctrl;

    function automatic logic [c2s_pkg::BND_W-1:0] clip_row(input logic [c2s_pkg::BND_W-1:0] v);
        clip_row = (v > c2s_pkg::BND_W'(c2s_pkg::ROWS)) ? c2s_pkg::BND_W'(c2s_pkg::ROWS) : v;
    endfunction

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // interval walk end points
    always_comb begin
        t1s = c2s_pkg::BND_W'(r_pt);
        b1s = c2s_pkg::BND_W'(r_pb);
        t2s = c2s_pkg::BND_W'(r_ct);
        b2s = c2s_pkg::BND_W'(r_cb);

        if ((t1s < t2s) && (t1s <= b1s)) begin
            t1e = (t2s < b1s + 9'd1) ? t2s : b1s + 9'd1;
        end else begin
            t1e = t1s;
        end

        if ((b1s > b2s) && (b1s >= t1e)) begin
            b1e = (b2s >= t1e) ? b2s : t1e - 9'd1;
        end else begin
            b1e = b1s;
        end

        if ((t2s < t1e) && (t2s <= b2s)) begin
            t2e = (t1e < b2s + 9'd1) ? t1e : b2s + 9'd1;
        end else begin
            t2e = t2s;
        end

        if ((b2s > b1e) && (b2s >= t2e)) begin
            b2e = (b1e >= t2e) ? b1e : t2e - 9'd1;
        end else begin
            b2e = b2s;
        end

        n_bnd.t1s = t1s;
        n_bnd.t1e = t1e;
        n_bnd.b1e = b1e;
        n_bnd.b1s = b1s;
        n_bnd.t2s = t2s;
        n_bnd.t2e = t2e;
        n_bnd.b2e = b2e;
        n_bnd.b2s = b2s;
    end

    assign ntop = c2s_pkg::CW'(clip_row(r_bnd.t1e) - clip_row(r_bnd.t1s));
    assign nbot = c2s_pkg::CW'(clip_row(r_bnd.b1s + 9'd1) - clip_row(r_bnd.b1e + 9'd1));

    assign advance  = !r_out_valid || !i_out_stall;
    assign in_shift = ((r_state == S_TSHIFT) || (r_state == S_BSHIFT)) && (r_phase_left != '0);
    assign head     = (r_state == S_BSHIFT) ? head_hi : head_lo;
    assign emit     = in_shift && head.valid && advance;

    always_comb begin
        ctrl.load_top = (r_state == S_TLOAD);
        ctrl.load_bot = (r_state == S_BLOAD);
        ctrl.shift    = in_shift && (!head.valid || advance);
        ctrl.shift_up = (r_state == S_BSHIFT);
        ctrl.open_wr  = (r_state == S_OPEN);
        ctrl.col      = r_col;
    end

    c2s_chain u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bnd     (r_bnd),
        .i_ctrl    (ctrl),
        .o_head_lo (head_lo),
        .o_head_hi (head_hi)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_CALC;
                end
            end
            S_CALC:  n_state = S_TLOAD;
            S_TLOAD: n_state = S_TSHIFT;
            S_TSHIFT: begin
                if (r_phase_left == '0) begin
                    n_state = S_BLOAD;
                end
            end
            S_BLOAD: n_state = S_BSHIFT;
            S_BSHIFT: begin
                if (r_phase_left == '0) begin
                    n_state = S_OPEN;
                end
            end
            S_OPEN:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase_left <= '0;
            r_left       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == S_TLOAD) begin
                r_phase_left <= ntop;
                r_left       <= ntop + nbot;
            end else if (r_state == S_BLOAD) begin
                r_phase_left <= r_nbot;
            end else if (emit) begin
                r_phase_left <= r_phase_left - 1'b1;
                r_left       <= r_left - 1'b1;
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_col   <= i_column;
            r_pt    <= i_prev_top;
            r_pb    <= i_prev_bottom;
            r_ct    <= i_cur_top;
            r_cb    <= i_cur_bottom;
            r_final <= (i_column == '0) ? c2s_pkg::LAST_COL : i_column - 1'b1;
        end

        if (r_state == S_CALC) begin
            r_bnd <= n_bnd;
        end

        if (r_state == S_TLOAD) begin
            r_nbot <= nbot;
            r_row  <= '0;
        end else if (r_state == S_BLOAD) begin
            r_row  <= c2s_pkg::RW'(c2s_pkg::ROWS - 1);
        end else if (ctrl.shift) begin
            r_row  <= ctrl.shift_up ? r_row - 1'b1 : r_row + 1'b1;
        end

        if (emit) begin
            r_span_row   <= c2s_pkg::ROW_W'(r_row);
            r_span_first <= head.start;
            r_span_final <= r_final;
            r_last_span  <= (r_left == c2s_pkg::CW'(1));
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_span_row   = r_span_row;
    assign o_span_first = r_span_first;
    assign o_span_final = r_span_final;
    assign o_last_span  = r_last_span;

    a_open_after_all_spans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OPEN) |-> (r_left == '0))
        else $error("start update while spans remain");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_left == '0))
        else $error("idle with spans remaining");

    a_top_head_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_TSHIFT) && head_lo.valid) |-> (r_phase_left != '0))
        else $error("top span at chain end beyond count");

    a_bot_head_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_BSHIFT) && head_hi.valid) |-> (r_phase_left != '0))
        else $error("bottom span at chain end beyond count");

    a_phase_within_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_TSHIFT) || (r_state == S_BSHIFT)) |-> (r_phase_left <= r_left))
        else $error("phase count exceeds total count");

endmodule
